// ----- rtl/pct_pkg.sv -----
package pct_pkg;

  // Number of features used by the classifier; the input word always
  // carries MAX_FEATURES slots.
  localparam int MAX_FEATURES = 4;
  localparam int NUM_FEATURES = 4;
  localparam int NUM_LANES    = NUM_FEATURES + 1;

  localparam int FEAT_W = 16;               // Q8.8 feature
  localparam int LR_W   = 16;               // Q0.16 learning rate
  localparam int W_W    = 32;               // Q16.16 weight
  localparam int X_W    = FEAT_W + 1;       // lane input, wide enough for 1.0
  localparam int SCL_W  = LR_W + 1 + X_W;   // learning rate times input
  localparam int RND_W  = SCL_W + 2;        // doubled, rounded step before shift
  localparam int FRAC_SHIFT = 8;            // Q8.24 to Q16.16
  localparam int STEP_W = RND_W - FRAC_SHIFT;
  localparam int PROD_W = W_W + X_W;        // Q25.24 product
  localparam int DOT_W  = PROD_W + $clog2(NUM_LANES) + 1;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;
  localparam int LABEL_BIT  = MAX_FEATURES * FEAT_W;

  localparam logic [LR_W-1:0]        LR_RESET   = 16'd655;
  localparam logic signed [X_W-1:0]  BIAS_INPUT = 17'sd256;

  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_TRAIN    = 1'b1;

  // Weight update control handed from the top level to every lane.
  typedef struct packed {
    logic apply;    // update the weights this cycle
    logic step_up;  // label is +1, so the error is +2; otherwise -2
  } upd_ctl_t;

endpackage

// ----- rtl/pct_lane.sv -----
module pct_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [pct_pkg::LR_W-1:0]             lr,
  input  logic signed [pct_pkg::X_W-1:0]       x,
  input  pct_pkg::upd_ctl_t                    ctl,
  output logic signed [pct_pkg::PROD_W-1:0]    prod
);
  import pct_pkg::*;

  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(128);
  localparam logic signed [W_W:0]     W_MAX    = {2'b00, {(W_W-1){1'b1}}};
  localparam logic signed [W_W:0]     W_MIN    = {2'b11, {(W_W-1){1'b0}}};

  logic signed [X_W-1:0]    x_r;
  logic signed [STEP_W-1:0] up_r, up_nxt;
  logic signed [STEP_W-1:0] dn_r, dn_nxt;
  logic signed [W_W-1:0]    w_r, w_nxt;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [RND_W-1:0]  up_full, dn_full;
  logic signed [STEP_W-1:0] step;
  logic signed [W_W:0]      w_sum;

  // Both possible steps are prepared when the word arrives, since they do
  // not depend on the weights. Rounding is to nearest, ties toward +inf.
  always_comb begin
    scaled  = SCL_W'($signed({1'b0, lr})) * SCL_W'(x);
    up_full = (RND_W'(scaled) <<< 1) + RND_HALF;
    dn_full = RND_HALF - (RND_W'(scaled) <<< 1);
    up_nxt  = STEP_W'(up_full >>> FRAC_SHIFT);
    dn_nxt  = STEP_W'(dn_full >>> FRAC_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= x;
      up_r <= up_nxt;
      dn_r <= dn_nxt;
    end
  end

  assign prod = PROD_W'(w_r) * PROD_W'(x_r);

  always_comb begin
    step  = ctl.step_up ? up_r : dn_r;
    w_sum = (W_W+1)'(w_r) + (W_W+1)'(step);
    w_nxt = w_r;
    if (ctl.apply) begin
      if (w_sum > W_MAX) begin
        w_nxt = W_W'(W_MAX);
      end else if (w_sum < W_MIN) begin
        w_nxt = W_W'(W_MIN);
      end else begin
        w_nxt = W_W'(w_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
    end else begin
      w_r <= w_nxt;
    end
  end

endmodule

// ----- rtl/pct_merge.sv -----
module pct_merge (
  input  logic signed [pct_pkg::PROD_W-1:0] prod [pct_pkg::NUM_LANES],
  output logic                              negative
);
  import pct_pkg::*;

  logic signed [DOT_W-1:0] dot;

  // Exact Q29.24 sum of the lane products; only its sign is needed.
  always_comb begin
    dot = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      dot = dot + DOT_W'(prod[k]);
    end
    negative = dot[DOT_W-1];
  end

endmodule

// ----- rtl/perceptron_classify_and_train_top.sv -----
// Online binary perceptron with four Q8.8 features and Q16.16 weights.
// Input channel: one word per sample. in_tuser selects classify or train,
// in_tdata carries the features and the true class.
// Result channel: one word per input word, giving the predicted class
// (taken before any update) and a flag set when it differs from the label.
// Configuration: cfg_wr_en writes cfg_wr_data into the learning rate; write
// it only while no word is in flight.
// Words move from sample to result stage. Throughput is one word per clock
// when not stalled: the learning-rate products are formed in the first
// stage, and in the second each lane multiplies its weight by its input,
// the merge stage sums the five products and takes the sign, and the
// weights update in that same cycle, so the next word already sees them.
// Reset (synchronous, rst_n low) clears all weights to zero, sets the
// learning rate to 655 and empties both stages.
// When the receiver stalls, the result register holds its word, the sample
// stage holds one more, and in_tready drops until the result is taken.
module perceptron_classify_and_train_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pct_pkg::LR_W-1:0]          cfg_wr_data,   // step size, Q0.16
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // feature_0 [15:0], feature_1 [31:16], feature_2 [47:32], feature_3 [63:48],
  // target_class [64], zero fill [71:65]
  input  logic [pct_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,      // operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // predicted_class [0], mismatch [1], zero fill [7:2]
  output logic [pct_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import pct_pkg::*;

  logic [LR_W-1:0] lr_r;
  logic            s1_valid_r, s1_train_r, s1_label_r;
  logic            out_valid_r, out_pred_r, out_mis_r;
  logic            in_fire, advance;
  logic            negative, pred, mis;
  upd_ctl_t        ctl;

  logic signed [X_W-1:0]    lane_x    [NUM_LANES];
  logic signed [PROD_W-1:0] lane_prod [NUM_LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
    end else if (cfg_wr_en) begin
      lr_r <= cfg_wr_data;
    end
  end

  // The sample stage moves on whenever the result register is free or
  // being emptied this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign lane_x[0] = BIAS_INPUT;

  for (genvar k = 1; k < NUM_LANES; k++) begin : g_feat
    assign lane_x[k] = X_W'($signed(in_tdata[(k-1)*FEAT_W +: FEAT_W]));
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    pct_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (in_fire),
      .lr    (lr_r),
      .x     (lane_x[k]),
      .ctl   (ctl),
      .prod  (lane_prod[k])
    );
  end

  pct_merge u_merge (
    .prod     (lane_prod),
    .negative (negative)
  );

  // A zero sum predicts +1. Weights change only on a wrong training guess.
  always_comb begin
    pred        = !negative;
    mis         = pred != s1_label_r;
    ctl.apply   = advance && (s1_train_r == OP_TRAIN) && mis;
    ctl.step_up = s1_label_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_train_r <= in_tuser;
      s1_label_r <= in_tdata[LABEL_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pred_r <= pred;
      out_mis_r  <= mis;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_mis_r, out_pred_r};

endmodule

// ----- rtl/pct_checker.sv -----
module pct_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pct_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import pct_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // Every accepted word is followed by a valid result word, registered after the sample stage.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("no result two cycles after acceptance");

  // The input stalls only behind a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty result register");

endmodule

bind perceptron_classify_and_train_top pct_checker u_pct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
